### rtl/nfb_pkg.sv
// ----------------------------------------------------------------------------
// nfb_pkg
// Types, codes, constants and the palette for the packed 4bpp frame store.
// ----------------------------------------------------------------------------
`default_nettype none

package nfb_pkg;

  localparam int FW_W  = 11;  // frame_width register
  localparam int FH_W  = 10;  // frame_height register
  localparam int X_W   = 10;
  localparam int Y_W   = 9;
  localparam int PIX_W = 21;  // y * width + x

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [7:0] NIB_HI_MASK = 8'hF0;
  localparam logic [7:0] NIB_LO_MASK = 8'h0F;
  localparam logic [7:0] FILL_WHITE  = 8'h11;

  typedef struct packed {
    logic [1:0]     func;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic [3:0]     color;
  } req_t;

  typedef struct packed {
    logic [3:0] pixel_color;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_frame;
  } rsp_t;

  // RGB of a colour index, indices above 7 clamped to 7
  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = {8'd57,  8'd48,  8'd57};
      4'd1:    rgb = {8'd255, 8'd255, 8'd255};
      4'd2:    rgb = {8'd58,  8'd91,  8'd70};
      4'd3:    rgb = {8'd61,  8'd59,  8'd94};
      4'd4:    rgb = {8'd156, 8'd72,  8'd75};
      4'd5:    rgb = {8'd208, 8'd190, 8'd71};
      4'd6:    rgb = {8'd177, 8'd106, 8'd73};
      default: rgb = {8'd255, 8'd255, 8'd255};
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

### rtl/nfb_store.sv
// ----------------------------------------------------------------------------
// nfb_store
// Single-port byte memory holding the packed pixels; registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module nfb_store #(
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = 18
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [7:0]        wdata,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### rtl/nfb_ctrl.sv
// ----------------------------------------------------------------------------
// nfb_ctrl
// Sequencer: address calculation, nibble read-modify-write, clear sweep
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nfb_ctrl
  import nfb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [FW_W-1:0] eff_w,
  input  wire logic [FH_W-1:0] eff_h,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire req_t            req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output rsp_t                 rsp
);

  localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT + 1) / 2;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CNT_W       = ADDR_W + 1;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_CALC, S_READ, S_MOD, S_DONE
  } state_t;

  state_t            state;
  req_t              item;
  logic              hit;
  logic              pix_odd;
  logic [ADDR_W-1:0] byte_addr;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  last;
  logic [7:0]        fill;
  logic              sweep_init;
  rsp_t              res;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata;

  logic              calc_hit;
  logic [PIX_W-1:0]  calc_pix;
  logic [PIX_W-1:0]  calc_area;
  logic [PIX_W-1:0]  calc_bytes;
  logic [3:0]        rd_nib;
  rsp_t              calc_res;
  rsp_t              mod_res;

  assign calc_hit   = ({1'b0, item.x} < eff_w) && ({1'b0, item.y} < eff_h);
  assign calc_pix   = PIX_W'(item.y) * PIX_W'(eff_w) + PIX_W'(item.x);
  assign calc_area  = PIX_W'(eff_w) * PIX_W'(eff_h);
  assign calc_bytes = (calc_area + PIX_W'(1)) >> 1;
  assign rd_nib     = pix_odd ? mem_rdata[3:0] : mem_rdata[7:4];

  assign req_stall  = (state != S_IDLE);

  // result as known after address calculation
  always_comb begin
    calc_res = '0;
    case (item.func)
      FUNC_READ: begin
        if (!calc_hit) begin
          {calc_res.red, calc_res.green, calc_res.blue} = palette_rgb(4'd0);
        end
      end
      FUNC_CLEAR: begin
        calc_res.in_frame = 1'b1;
      end
      default: begin
        calc_res = '0;
      end
    endcase
  end

  // result of a pixel operation inside the frame
  always_comb begin
    mod_res          = '0;
    mod_res.in_frame = 1'b1;
    if (item.func == FUNC_READ) begin
      mod_res.pixel_color                            = rd_nib;
      {mod_res.red, mod_res.green, mod_res.blue} = palette_rgb(rd_nib);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = byte_addr;
    mem_wdata = fill;
    case (state)
      S_SWEEP: begin
        mem_we   = 1'b1;
        mem_addr = cnt[ADDR_W-1:0];
      end
      S_MOD: begin
        mem_we = (item.func == FUNC_WRITE) && hit;
        if (pix_odd) begin
          mem_wdata = (mem_rdata & NIB_HI_MASK) | {4'h0, item.color};
        end else begin
          mem_wdata = (mem_rdata & NIB_LO_MASK) | {item.color, 4'h0};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  nfb_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      cnt        <= '0;
      last       <= CNT_W'(STORE_BYTES - 1);
      fill       <= FILL_WHITE;
      sweep_init <= 1'b1;
      rsp_valid  <= 1'b0;
    end else begin
      // present a finished result, drop the flag once it transfers
      if (state == S_DONE) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == last) begin
            state <= sweep_init ? S_IDLE : S_DONE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          hit       <= calc_hit;
          pix_odd   <= calc_pix[0];
          byte_addr <= ADDR_W'(calc_pix >> 1);
          res       <= calc_res;
          case (item.func)
            FUNC_WRITE: begin
              state <= calc_hit ? S_READ : S_DONE;
            end
            FUNC_READ: begin
              state <= calc_hit ? S_READ : S_DONE;
            end
            FUNC_CLEAR: begin
              cnt        <= '0;
              last       <= CNT_W'(calc_bytes) - CNT_W'(1);
              fill       <= {item.color, item.color};
              sweep_init <= 1'b0;
              state      <= (calc_bytes == '0) ? S_DONE : S_SWEEP;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          state <= S_MOD;
        end
        S_MOD: begin
          res   <= mod_res;
          state <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_rmw_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && mem_we) |-> (hit && item.func == FUNC_WRITE))
    else $error("nibble write-back outside the frame");

  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == S_CALC))
    else $error("accepted transfer not taken into address calculation");

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> (cnt <= last))
    else $error("clear sweep ran past its last byte");
`endif

endmodule

`default_nettype wire

### rtl/nibble_framebuffer_engine_unit.sv
// ----------------------------------------------------------------------------
// nibble_framebuffer_engine_unit
// Packed 4bpp frame store: pixel write, pixel read with palette lookup,
// whole-frame clear. Two pixels per byte, even pixel in the high nibble.
//
//   channel  | signals                          | carries
//   ---------+----------------------------------+------------------------------
//   req      | req_valid, req_stall, req        | func, x, y, color
//   rsp      | rsp_valid, rsp_stall, rsp        | pixel_color, RGB, in_frame
//   config   | wr_en, wr_index, wr_data         | frame_width, frame_height
//
// One item at a time. A pixel write or read in the frame passes calc, memory
// read, modify/write-back and result; a miss or unused code goes from calc
// straight to the result. req_stall drops as the result is presented. Clear
// sweeps (width * height + 1) / 2 bytes, one per cycle through the single
// memory port, before its result.
// After reset a sweep writes 0x11 to every byte, (MAX_WIDTH * MAX_HEIGHT + 1)
// / 2 bytes (262144 at the defaults), with req_stall high throughout.
// A new request is taken while a result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_framebuffer_engine_unit
  import nfb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire req_t            req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output rsp_t                 rsp,
  input  wire logic            wr_en,
  input  wire logic            wr_index,
  input  wire logic [FW_W-1:0] wr_data
);

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [FW_W-1:0] eff_w;
  logic [FH_W-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(600);
      frame_height <= FH_W'(448);
    end else if (wr_en) begin
      case (wr_index)
        REG_WIDTH:  frame_width  <= wr_data;
        REG_HEIGHT: frame_height <= wr_data[FH_W-1:0];
        default:    frame_width  <= frame_width;
      endcase
    end
  end

  // clamp oversized registers to the store geometry
  assign eff_w = (32'(frame_width) > 32'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : frame_width;
  assign eff_h = (32'(frame_height) > 32'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : frame_height;

  nfb_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

### test/frame_store_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_store_checker
// Watches the request, result and register ports of the packed 4bpp frame
// store. It keeps its own copy of the frame and the frame size, works out the
// result of every request transfer, and compares each result transfer field
// by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module frame_store_checker
  import nfb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_stall,
  input  req_t            req,
  input  logic            rsp_valid,
  input  logic            rsp_stall,
  input  rsp_t            rsp,
  input  logic            wr_en,
  input  logic            wr_index,
  input  logic [FW_W-1:0] wr_data,
  output int              pending,
  output int              errors
);

  localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT + 1) / 2;

  logic [7:0]      frame_mem [STORE_BYTES];
  logic [23:0]     rgb_lut [8];
  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  rsp_t            rsp_due_q [$];
  rsp_t            want;

  initial begin
    rgb_lut[0] = {8'd57,  8'd48,  8'd57};
    rgb_lut[1] = {8'd255, 8'd255, 8'd255};
    rgb_lut[2] = {8'd58,  8'd91,  8'd70};
    rgb_lut[3] = {8'd61,  8'd59,  8'd94};
    rgb_lut[4] = {8'd156, 8'd72,  8'd75};
    rgb_lut[5] = {8'd208, 8'd190, 8'd71};
    rgb_lut[6] = {8'd177, 8'd106, 8'd73};
    rgb_lut[7] = {8'd255, 8'd255, 8'd255};
  end

  // Apply one request to the frame copy and return the result it should give
  function automatic rsp_t predict_pixel_op(input req_t r);
    rsp_t        res;
    int unsigned w, h, pix, byte_at, fill_len;
    logic        hit;
    logic [3:0]  got;
    logic [23:0] rgb;
    res = '0;
    got = '0;
    w   = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    h   = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    hit = (r.x < w) && (r.y < h);
    pix = hit ? (r.y * w + r.x) : 0;
    byte_at = pix >> 1;
    if (byte_at >= STORE_BYTES) hit = 1'b0;
    case (r.func)
      FUNC_WRITE: begin
        if (hit) begin
          if (pix[0]) frame_mem[byte_at][3:0] = r.color;
          else frame_mem[byte_at][7:4] = r.color;
        end
        res.in_frame = hit;
      end
      FUNC_READ: begin
        if (hit) got = pix[0] ? frame_mem[byte_at][3:0] : frame_mem[byte_at][7:4];
        rgb = rgb_lut[(got > 4'd7) ? 3'd7 : got[2:0]];
        res.pixel_color = got;
        res.red         = rgb[23:16];
        res.green       = rgb[15:8];
        res.blue        = rgb[7:0];
        res.in_frame    = hit;
      end
      FUNC_CLEAR: begin
        // whole bytes from the start, so an odd pixel count fills one spare nibble
        fill_len = (w * h + 1) / 2;
        if (fill_len > STORE_BYTES) fill_len = STORE_BYTES;
        for (int i = 0; i < fill_len; i++) frame_mem[i] = {r.color, r.color};
        res.in_frame = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = 11'd600;
      height_reg = 10'd448;
      for (int i = 0; i < STORE_BYTES; i++) frame_mem[i] = FILL_WHITE;
      rsp_due_q.delete();
      pending = 0;
      errors  = 0;
    end else begin
      // compare before queueing, so a stray result is never matched to a new request
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due_q.size() == 0) begin
          $display("%0t: unexpected result transfer: expected none, actual %h", $time, rsp);
          errors++;
        end else begin
          want = rsp_due_q.pop_front();
          check_field("pixel_color", 8'(want.pixel_color), 8'(rsp.pixel_color));
          check_field("red",         want.red,             rsp.red);
          check_field("green",       want.green,           rsp.green);
          check_field("blue",        want.blue,            rsp.blue);
          check_field("in_frame",    8'(want.in_frame),    8'(rsp.in_frame));
        end
      end
      if (req_valid && !req_stall) rsp_due_q.push_back(predict_pixel_op(req));
      if (wr_en) begin
        if (wr_index == REG_WIDTH) width_reg = wr_data;
        else height_reg = wr_data[FH_W-1:0];
      end
      pending = rsp_due_q.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the packed 4bpp frame store through directed pixel writes, reads and
// clears at the frame-size extremes, then random phases of mostly small frames
// with random gaps on both channels. Checking is done by frame_store_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import nfb_pkg::*;

  localparam int         MAX_WIDTH      = 1024;
  localparam int         MAX_HEIGHT     = 512;
  localparam logic [1:0] FUNC_SPARE     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 800000;
  localparam int         TAIL_CYCLES    = 16;
  localparam int         PHASES         = 8;
  localparam int         PHASE_ITEMS    = 180;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            req_valid = 1'b0;
  logic            rsp_stall = 1'b0;
  logic            wr_en     = 1'b0;
  logic            wr_index  = REG_WIDTH;
  logic [FW_W-1:0] wr_data   = '0;
  req_t            req       = '0;
  logic            req_stall;
  logic            rsp_valid;
  rsp_t            rsp;

  int              pending;
  int              errors;
  int              quiet_cycles = 0;
  int              stall_hold   = 0;
  logic            calm         = 1'b0;
  logic [FW_W-1:0] cur_w        = 11'd600;
  logic [FH_W-1:0] cur_h        = 10'd448;
  req_t            recent_q [$];

  nibble_framebuffer_engine_unit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  frame_store_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      rsp_stall  <= calm ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic req_t pixel_op(input logic [1:0] func, input int x, input int y,
                                    input int color);
    req_t r;
    r.func  = func;
    r.x     = X_W'(x);
    r.y     = Y_W'(y);
    r.color = 4'(color);
    return r;
  endfunction

  // Hold the request until it transfers; returns in the step of the transfer
  task automatic send_item(input req_t item);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    if (item.func == FUNC_WRITE) begin
      recent_q.push_back(item);
      if (recent_q.size() > 16) recent_q.delete(0);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_frame(input logic [FW_W-1:0] w, input logic [FH_W-1:0] h);
    drain();
    wr_en    <= 1'b1;
    wr_index <= REG_WIDTH;
    wr_data  <= w;
    @(posedge clk);
    wr_index <= REG_HEIGHT;
    wr_data  <= FW_W'(h);
    @(posedge clk);
    wr_en <= 1'b0;
    cur_w = w;
    cur_h = h;
    recent_q.delete();
  endtask

  function automatic req_t random_item();
    req_t        it;
    req_t        pick;
    int unsigned w, h, roll;
    it = '0;
    w  = (cur_w > MAX_WIDTH) ? MAX_WIDTH : cur_w;
    h  = (cur_h > MAX_HEIGHT) ? MAX_HEIGHT : cur_h;
    it.color = 4'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    // keep clears cheap: only small frames get them
    if (roll < 3) it.func = FUNC_SPARE;
    else if (roll < 7 && w * h <= 8192) it.func = FUNC_CLEAR;
    else if (roll < 52) it.func = FUNC_WRITE;
    else it.func = FUNC_READ;
    if (w == 0 || h == 0 || $urandom_range(0, 99) < 12) begin
      it.x = X_W'($urandom_range(0, 1023));
      it.y = Y_W'($urandom_range(0, 511));
    end else if (it.func == FUNC_READ && recent_q.size() != 0 && $urandom_range(0, 1)) begin
      // read back a recent write, or its neighbour with the lowest x bit flipped
      pick = recent_q[$urandom_range(0, recent_q.size() - 1)];
      it.x = pick.x;
      it.y = pick.y;
      if ($urandom_range(0, 3) == 0) it.x[0] = ~it.x[0];
    end else begin
      it.x = X_W'($urandom_range(0, w - 1));
      it.y = Y_W'($urandom_range(0, h - 1));
    end
    return it;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // wait out the fill sweep after reset
    while (!req_stall) @(posedge clk);
    while (req_stall) @(posedge clk);

    // reset frame size
    send_item(pixel_op(FUNC_READ, 0, 0, 0));
    send_item(pixel_op(FUNC_READ, 599, 447, 0));
    send_item(pixel_op(FUNC_READ, 600, 0, 0));
    send_item(pixel_op(FUNC_WRITE, 0, 448, 5));
    send_item(pixel_op(FUNC_SPARE, 1023, 511, 15));

    // oversized registers clamp to the largest frame
    set_frame(11'd2047, 10'd1023);
    send_item(pixel_op(FUNC_WRITE, 1023, 511, 15));
    send_item(pixel_op(FUNC_READ, 1023, 511, 0));
    send_item(pixel_op(FUNC_WRITE, 1, 0, 9));
    send_item(pixel_op(FUNC_READ, 0, 0, 0));
    send_item(pixel_op(FUNC_READ, 1, 0, 0));
    send_item(pixel_op(FUNC_WRITE, 0, 0, 0));
    send_item(pixel_op(FUNC_READ, 0, 0, 0));
    send_item(pixel_op(FUNC_CLEAR, 0, 0, 10));
    send_item(pixel_op(FUNC_READ, 1023, 511, 0));

    set_frame(11'd1024, 10'd512);
    send_item(pixel_op(FUNC_WRITE, 1023, 511, 7));
    send_item(pixel_op(FUNC_READ, 1023, 511, 0));
    send_item(pixel_op(FUNC_READ, 0, 0, 0));

    // empty frames: nothing hits, clear touches no byte
    set_frame(11'd0, 10'd512);
    send_item(pixel_op(FUNC_WRITE, 0, 0, 3));
    send_item(pixel_op(FUNC_CLEAR, 0, 0, 5));
    set_frame(11'd5, 10'd0);
    send_item(pixel_op(FUNC_READ, 0, 0, 0));

    // odd pixel count: the clear runs to the end of the last byte and no further
    set_frame(11'd3, 10'd3);
    send_item(pixel_op(FUNC_CLEAR, 0, 0, 6));
    set_frame(11'd8, 10'd8);
    send_item(pixel_op(FUNC_READ, 1, 1, 0));
    send_item(pixel_op(FUNC_READ, 2, 1, 0));
    send_item(pixel_op(FUNC_READ, 4, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        2:       set_frame(FW_W'($urandom_range(1000, 2047)), FH_W'($urandom_range(1, 4)));
        5:       set_frame(11'd0, FH_W'($urandom_range(0, 1023)));
        7:       set_frame(FW_W'($urandom_range(1, 2047)), FH_W'($urandom_range(1, 1023)));
        default: set_frame(FW_W'($urandom_range(1, 40)), FH_W'($urandom_range(1, 24)));
      endcase
      calm = (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_item(random_item());
        if ($urandom_range(0, 149) == 0) drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
